// ----- rtl/lrbr_pkg.sv -----
package lrbr_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // CORDIC datapath width: Q2.30 values with headroom for the folded angle error.
    localparam int CW = 34;

    localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic_lane;

    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic t_cordic_lane cordic_step(input t_cordic_lane a, input int unsigned sh);
        t_cordic_lane b;
        logic signed [CW-1:0] at;
        at = $signed(CW'(atan_turn(sh)));
        if (!a.z[CW-1]) begin
            b.x = a.x - ($signed(a.y) >>> sh);
            b.y = a.y + ($signed(a.x) >>> sh);
            b.z = a.z - at;
        end else begin
            b.x = a.x + ($signed(a.y) >>> sh);
            b.y = a.y - ($signed(a.x) >>> sh);
            b.z = a.z + at;
        end
        return b;
    endfunction

endpackage

// ----- rtl/landmark_range_bearing_residual.sv -----
// Range-bearing residual for a 2D vehicle pose against a known landmark. The block is a
// single pipeline of CORDIC_STAGES + 5 register stages: one input stage, one CORDIC
// stage per iteration (heading and bearing in parallel lanes), then rounding of the
// cosines and sines, six parallel multiplies, the sums, and a final round and saturate.
// It accepts one item per clock cycle while the output is not stalled, and presents each
// result from the final round and saturate register. The pipeline advances as a
// whole: while a finished result waits at the output, every stage holds and no item is
// taken. All outputs are Q16.16 and saturate to the signed 32-bit range.
module landmark_range_bearing_residual #(
    parameter int CORDIC_STAGES = lrbr_pkg::CORDIC_STAGES_DEF,
    parameter int FRACTION_BITS = lrbr_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic        [15:0] i_pose_heading,
    input  logic        [30:0] i_meas_range,
    input  logic        [15:0] i_meas_bearing,
    input  logic signed [31:0] i_landmark_x,
    input  logic signed [31:0] i_landmark_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_error_x,
    output logic signed [31:0] o_error_y,
    output logic signed [31:0] o_jac_x_heading,
    output logic signed [31:0] o_jac_y_heading
);

    localparam int CW   = lrbr_pkg::CW;
    localparam int N    = CORDIC_STAGES;
    localparam int NV   = N + 5;
    localparam int SH   = 30 - FRACTION_BITS;
    localparam int CSW  = CW - SH;
    localparam int PW   = 33 + CSW;
    localparam int AW   = PW + 2;

    localparam logic signed [CW-1:0] C_HALF  = CW'(1) << (SH - 1);
    localparam logic signed [CW-1:0] QTR     = CW'(64'sh40000000);
    localparam logic signed [AW-1:0] F_HALF  = AW'(1) << (FRACTION_BITS - 1);
    localparam logic signed [AW-1:0] SAT_HI  = AW'(64'sh7FFFFFFF);
    localparam logic signed [AW-1:0] SAT_LO  = AW'(-64'sh80000000);

    function automatic logic signed [31:0] finish(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] t;
        logic signed [31:0]   v;
        t = (a + F_HALF) >>> FRACTION_BITS;
        if (t > SAT_HI) begin
            v = 32'sh7FFFFFFF;
        end else if (t < SAT_LO) begin
            v = -32'sh80000000;
        end else begin
            v = t[31:0];
        end
        return v;
    endfunction

    function automatic logic signed [CSW-1:0] round_cs(input logic signed [CW-1:0] v,
                                                        input logic flip);
        logic signed [CW-1:0] n;
        logic signed [CW-1:0] t;
        n = flip ? -v : v;
        t = (n + C_HALF) >>> SH;
        return t[CSW-1:0];
    endfunction

    logic          en;
    logic [NV-1:0] r_vld;
    logic [NV-1:0] n_vld;

    assign en         = !r_vld[NV-1] || i_out_ready;
    assign o_in_ready = en;
    assign n_vld      = {r_vld[NV-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    lrbr_pkg::t_cordic_lane r_hd    [0:N];
    lrbr_pkg::t_cordic_lane r_bg    [0:N];
    logic                   r_hflip [0:N];
    logic                   r_bflip [0:N];
    logic signed [32:0]     r_dx    [0:N];
    logic signed [32:0]     r_dy    [0:N];
    logic [30:0]            r_rng   [0:N];

    logic                   hflip;
    logic                   bflip;
    logic [15:0]            hfold;
    logic [15:0]            bfold;
    lrbr_pkg::t_cordic_lane n_hd;
    lrbr_pkg::t_cordic_lane n_bg;

    always_comb begin
        hflip  = i_pose_heading[15] ^ i_pose_heading[14];
        bflip  = i_meas_bearing[15] ^ i_meas_bearing[14];
        hfold  = i_pose_heading ^ {hflip, 15'b0};
        bfold  = i_meas_bearing ^ {bflip, 15'b0};
        n_hd.x = $signed(CW'(lrbr_pkg::GAIN_Q30));
        n_hd.y = '0;
        n_hd.z = CW'($signed({hfold, 16'b0}));
        n_bg.x = $signed(CW'(lrbr_pkg::GAIN_Q30));
        n_bg.y = '0;
        n_bg.z = CW'($signed({bfold, 16'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hd[0]    <= n_hd;
            r_bg[0]    <= n_bg;
            r_hflip[0] <= hflip;
            r_bflip[0] <= bflip;
            r_dx[0]    <= 33'(i_landmark_x) - 33'(i_pose_x);
            r_dy[0]    <= 33'(i_landmark_y) - 33'(i_pose_y);
            r_rng[0]   <= i_meas_range;
        end
    end

    for (genvar g = 1; g <= N; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_hd[g]    <= lrbr_pkg::cordic_step(r_hd[g-1], g - 1);
                r_bg[g]    <= lrbr_pkg::cordic_step(r_bg[g-1], g - 1);
                r_hflip[g] <= r_hflip[g-1];
                r_bflip[g] <= r_bflip[g-1];
                r_dx[g]    <= r_dx[g-1];
                r_dy[g]    <= r_dy[g-1];
                r_rng[g]   <= r_rng[g-1];
            end
        end
    end

    logic signed [CSW-1:0] r_c;
    logic signed [CSW-1:0] r_s;
    logic signed [CSW-1:0] r_cb;
    logic signed [CSW-1:0] r_sb;
    logic signed [32:0]    r_rdx;
    logic signed [32:0]    r_rdy;
    logic signed [31:0]    r_rr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c   <= round_cs(r_hd[N].x, r_hflip[N]);
            r_s   <= round_cs(r_hd[N].y, r_hflip[N]);
            r_cb  <= round_cs(r_bg[N].x, r_bflip[N]);
            r_sb  <= round_cs(r_bg[N].y, r_bflip[N]);
            r_rdx <= r_dx[N];
            r_rdy <= r_dy[N];
            r_rr  <= $signed({1'b0, r_rng[N]});
        end
    end

    logic signed [PW-1:0] r_cdx;
    logic signed [PW-1:0] r_sdy;
    logic signed [PW-1:0] r_sdx;
    logic signed [PW-1:0] r_cdy;
    logic signed [PW-1:0] r_rcb;
    logic signed [PW-1:0] r_rsb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cdx <= PW'(r_c) * PW'(r_rdx);
            r_sdy <= PW'(r_s) * PW'(r_rdy);
            r_sdx <= PW'(r_s) * PW'(r_rdx);
            r_cdy <= PW'(r_c) * PW'(r_rdy);
            r_rcb <= PW'(r_cb) * PW'(r_rr);
            r_rsb <= PW'(r_sb) * PW'(r_rr);
        end
    end

    logic signed [AW-1:0] r_aex;
    logic signed [AW-1:0] r_aey;
    logic signed [AW-1:0] r_ajx;
    logic signed [AW-1:0] r_ajy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_aex <= AW'(r_cdx) + AW'(r_sdy) - AW'(r_rcb);
            r_aey <= AW'(r_cdy) - AW'(r_sdx) - AW'(r_rsb);
            r_ajx <= AW'(r_cdy) - AW'(r_sdx);
            r_ajy <= -AW'(r_cdx) - AW'(r_sdy);
        end
    end

    logic signed [31:0] r_ex;
    logic signed [31:0] r_ey;
    logic signed [31:0] r_jx;
    logic signed [31:0] r_jy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex <= finish(r_aex);
            r_ey <= finish(r_aey);
            r_jx <= finish(r_ajx);
            r_jy <= finish(r_ajy);
        end
    end

    assign o_out_valid     = r_vld[NV-1];
    assign o_error_x       = r_ex;
    assign o_error_y       = r_ey;
    assign o_jac_x_heading = r_jx;
    assign o_jac_y_heading = r_jy;

    // A stalled output freezes the whole pipeline.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    // An accepted item occupies the first stage in the next cycle.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    // The last internal stage moves into the output register when the pipeline advances.
    a_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[NV-2] |=> o_out_valid)
        else $error("item lost before the output register");

    // Folding keeps both CORDIC start angles within a quarter turn.
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_hd[0].z >= -QTR && r_hd[0].z < QTR
                      && r_bg[0].z >= -QTR && r_bg[0].z < QTR))
        else $error("folded angle outside the CORDIC convergence range");

endmodule
